// ===== hw/rtl/blh_pkg.sv =====
// Shared types, constants and helpers of the bucketed link hash table.
// Used by the top level; depends on nothing else.
package blh_pkg;

	// Fixed geometry of the bucket index.
	localparam int unsigned BUCKET_COUNT = 256;
	localparam int unsigned BUCKET_W = 8;
	localparam int unsigned CHAIN_DEPTH_DEF = 8;

	// Field widths of the stream payloads.
	localparam int unsigned IN_DATA_W = 48;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned COUNT_W = 6;

	// Command codes carried in tuser on the input side.
	typedef enum logic [1:0] {
		CMD_INSERT       = 2'd0,
		CMD_FIND_CONCEPT = 2'd1,
		CMD_FIND_NODE    = 2'd2,
		CMD_CLEAR        = 2'd3
	} cmd_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_NOT_EN = 2'd1,
		STATUS_FULL   = 2'd2
	} status_t;

	// One stored link, 40 bits.
	typedef struct packed {
		logic [7:0]  relation;
		logic [7:0]  weight;
		logic [7:0]  node;
		logic [15:0] concept;
	} link_t;

	localparam int unsigned LINK_W = $bits(link_t);

	// Bucket of a concept: low byte of (concept xor concept >> 4).
	function automatic logic [BUCKET_W-1:0] bucket_of(input logic [15:0] concept);
		bucket_of = concept[7:0] ^ concept[11:4];
	endfunction

endpackage

// ===== hw/rtl/blh_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// Stands alone; used by the top level for the fill counts and the link store.
module blh_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/bucketed_link_hash_table_unit.sv =====
// Bucketed link hash table. Links (node, concept, weight, relation) are kept in 256 buckets
// picked from the concept, up to CHAIN_DEPTH links per bucket in insertion order. One command
// is taken at a time and s_tready stays low until its last result transfer has been handed to
// the output register. An insert reads the bucket's fill count and then writes the link; a clear
// or a refused command goes straight to its result. A find by concept walks the entries of its
// bucket; a find by node walks every bucket, ending early once the limit is reached. Each entry
// walked takes a link read and a compare. A result that waits on m_tready stalls the walk. The
// link store has a single read port and is read one entry at a time, and the fill-count RAM is
// read once per bucket.
// Clear takes effect at once through per-bucket valid bits, so no clearing pass is needed.
module bucketed_link_hash_table_unit #(
	parameter int unsigned CHAIN_DEPTH = blh_pkg::CHAIN_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel: table_enabled.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	// Command stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tdata: node_key[7:0], concept_key[23:8], link_weight[31:24],
	// relation_kind[39:32], limit_count[45:40], zero fill[47:46]
	input  logic [blh_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser: command[1:0]
	input  logic [1:0]                     s_tuser,
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// tdata: out_status[1:0], out_node[9:2], out_concept[25:10],
	// out_weight[33:26], out_relation[41:34], match_count[47:42]
	output logic [blh_pkg::OUT_DATA_W-1:0] m_tdata,
	// tuser: is_match[0]
	output logic                           m_tuser,
	// tlast: last_item
	output logic                           m_tlast
);

	import blh_pkg::*;

	localparam int unsigned FILL_W = $clog2(CHAIN_DEPTH + 1);
	localparam int unsigned LINK_DEPTH = BUCKET_COUNT * CHAIN_DEPTH;
	localparam int unsigned LINK_AW = $clog2(LINK_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_START = 8'b0000_0010,
		S_FREAD = 8'b0000_0100,
		S_FCHK  = 8'b0000_1000,
		S_LREAD = 8'b0001_0000,
		S_LCMP  = 8'b0010_0000,
		S_MATCH = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic                  enabled_q;
	logic [BUCKET_COUNT-1:0] fill_vld_q;

	// Latched command.
	cmd_t                  cmd_q;
	logic [7:0]            node_q;
	logic [15:0]           concept_q;
	logic [7:0]            weight_q;
	logic [7:0]            relation_q;
	logic [COUNT_W-1:0]    limit_q;

	// Scan position and result bookkeeping.
	logic [BUCKET_W-1:0]   bucket_q;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     idx_q;
	logic [COUNT_W-1:0]    count_q;
	status_t               status_q;

	// Output register.
	logic                  m_tvalid_q;
	status_t               out_status_q;
	logic                  out_match_q;
	link_t                 out_link_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_last_q;

	// RAM ports.
	logic                  fill_wr_en;
	logic [FILL_W-1:0]     fill_wr_data;
	logic                  fill_rd_en;
	logic [FILL_W-1:0]     fill_rd_data;
	logic                  link_wr_en;
	logic [LINK_AW-1:0]    link_wr_addr;
	logic                  link_rd_en;
	logic [LINK_AW-1:0]    link_rd_addr;
	logic [LINK_W-1:0]     link_rd_raw;
	link_t                 link_rd;

	logic [FILL_W-1:0]     fill_cur;
	logic                  bucket_full;
	logic [LINK_AW-1:0]    bucket_base;
	logic                  entry_more;
	logic                  hit;
	logic                  slot_free;
	logic                  emit_match;
	logic                  emit_final;
	logic                  accept;
	link_t                 new_link;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;

	// A bucket whose valid bit is clear has been emptied since reset or clear.
	assign fill_cur    = fill_vld_q[bucket_q] ? fill_rd_data : '0;
	assign bucket_full = (fill_cur >= FILL_W'(CHAIN_DEPTH));
	assign bucket_base = LINK_AW'(LINK_AW'(bucket_q) * LINK_AW'(CHAIN_DEPTH));

	assign new_link = '{relation: relation_q, weight: weight_q, node: node_q,
		concept: concept_q};

	// Fill count and link store writes happen together on a successful insert.
	assign fill_wr_en   = (state_q == S_FCHK) && (cmd_q == CMD_INSERT) && !bucket_full;
	assign fill_wr_data = fill_cur + FILL_W'(1);
	assign fill_rd_en   = (state_q == S_FREAD);
	assign link_wr_en   = fill_wr_en;
	assign link_wr_addr = bucket_base + LINK_AW'(fill_cur);

	// Entry walk: one link read, then one compare.
	assign entry_more   = (idx_q < fill_q) && (count_q < limit_q);
	assign link_rd_en   = (state_q == S_LREAD) && entry_more;
	assign link_rd_addr = bucket_base + LINK_AW'(idx_q);
	assign link_rd      = link_t'(link_rd_raw);
	assign hit = (cmd_q == CMD_FIND_CONCEPT) ? (link_rd.concept == concept_q)
		: (link_rd.node == node_q);

	// The output register takes a new item when empty or being drained.
	assign slot_free  = !m_tvalid_q || m_tready;
	assign emit_match = (state_q == S_MATCH) && slot_free;
	assign emit_final = (state_q == S_DONE) && slot_free;

	blh_ram #(
		.WIDTH (FILL_W),
		.DEPTH (BUCKET_COUNT)
	) u_fill_ram (
		.clk     (clk),
		.wr_en   (fill_wr_en),
		.wr_addr (bucket_q),
		.wr_data (fill_wr_data),
		.rd_en   (fill_rd_en),
		.rd_addr (bucket_q),
		.rd_data (fill_rd_data)
	);

	blh_ram #(
		.WIDTH (LINK_W),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_wr_en),
		.wr_addr (link_wr_addr),
		.wr_data (new_link),
		.rd_en   (link_rd_en),
		.rd_addr (link_rd_addr),
		.rd_data (link_rd_raw)
	);

	// Control state: sequencer, enable register, bucket valid bits, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			enabled_q  <= 1'b0;
			fill_vld_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enabled_q <= cfg_data;
			end
			// The output register fills on a new item and empties on a transfer.
			if (emit_match || emit_final) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (!enabled_q) begin
						state_q <= S_DONE;
					end else if (cmd_q == CMD_CLEAR) begin
						fill_vld_q <= '0;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_FREAD;
					end
				end
				S_FREAD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (cmd_q == CMD_INSERT) begin
						if (!bucket_full) begin
							fill_vld_q[bucket_q] <= 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_LREAD;
					end
				end
				S_LREAD: begin
					if (entry_more) begin
						state_q <= S_LCMP;
					end else if ((cmd_q == CMD_FIND_NODE) && (bucket_q != '1)
						&& (count_q < limit_q)) begin
						state_q <= S_FREAD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LCMP: begin
					state_q <= hit ? S_MATCH : S_LREAD;
				end
				S_MATCH: begin
					if (slot_free) begin
						state_q <= S_LREAD;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the command being served.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q      <= cmd_t'(s_tuser);
					node_q     <= s_tdata[7:0];
					concept_q  <= s_tdata[23:8];
					weight_q   <= s_tdata[31:24];
					relation_q <= s_tdata[39:32];
					limit_q    <= s_tdata[45:40];
				end
			end
			S_START: begin
				count_q  <= '0;
				status_q <= enabled_q ? STATUS_OK : STATUS_NOT_EN;
				bucket_q <= (cmd_q == CMD_FIND_NODE) ? '0 : bucket_of(concept_q);
			end
			S_FCHK: begin
				fill_q <= fill_cur;
				idx_q  <= '0;
				if ((cmd_q == CMD_INSERT) && bucket_full) begin
					status_q <= STATUS_FULL;
				end
			end
			S_LREAD: begin
				if (!entry_more) begin
					bucket_q <= bucket_q + BUCKET_W'(1);
				end
			end
			S_LCMP: begin
				if (!hit) begin
					idx_q <= idx_q + FILL_W'(1);
				end
			end
			S_MATCH: begin
				if (slot_free) begin
					idx_q   <= idx_q + FILL_W'(1);
					count_q <= count_q + COUNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (emit_match || emit_final) begin
			out_status_q <= emit_match ? STATUS_OK : status_q;
			out_match_q  <= emit_match;
			out_link_q   <= emit_match ? link_rd : '0;
			out_count_q  <= emit_match ? '0 : count_q;
			out_last_q   <= emit_final;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_count_q, out_link_q.relation, out_link_q.weight,
		out_link_q.concept, out_link_q.node, out_status_q};
	assign m_tuser  = out_match_q;
	assign m_tlast  = out_last_q;

endmodule
